FILE: hw/rtl/wsh_pkg.sv
// shared constants and types for the windowed deviation to hysteresis width block
package wsh_pkg;

   localparam int SampleWidth = 16;
   localparam int WindowWidth = 10;
   localparam int IndexOutWidth = 10;
   localparam int CsrIndexWidth = 3;

   localparam logic [CsrIndexWidth-1:0] CSR_WINDOW_SIZE = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_HYST_LOW    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_HYST_HIGH   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_STD_LOW     = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_STD_HIGH    = 3'd4;

   localparam logic [WindowWidth-1:0] WINDOW_RESET   = 10'd16;
   localparam logic [SampleWidth-1:0] STD_HIGH_RESET = 16'd1;

   typedef logic signed [SampleWidth-1:0] sample_type;

endpackage

FILE: hw/rtl/windowed_std_hysteresis_width.sv
// windowed standard deviation of torque samples mapped to a hysteresis width
//
//  channel | ports                                   | direction
//  req     | req_valid req_stall req_torque_sample   | in
//  rsp     | rsp_valid rsp_stall rsp_hyst_width      | out
//          | rsp_std_dev rsp_next_index              |
//  csr     | csr_valid csr_ready csr_index csr_data  | in
//
// a request is accepted and the store walked (one entry per read port cycle); three
// shift-add multiplier products and a restoring divider quotient give the variance,
// the root unit its square root; after map setup a fourth product and a second quotient
// give the width, then the output step; both are skipped when std_low equals std_high
// reset is synchronous; the store needs no clearing, a fill count marks written entries
// a new request is taken while a result is still held on rsp, but not while one is computed
// csr writes are always taken
module windowed_std_hysteresis_width
   import wsh_pkg::*;
#(
   parameter int STORE_DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [SampleWidth-1:0]   req_torque_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [SampleWidth-1:0]   rsp_hyst_width,
   output logic [SampleWidth-1:0]   rsp_std_dev,
   output logic [IndexOutWidth-1:0] rsp_next_index,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [SampleWidth-1:0]   csr_data
);

   localparam int AW   = (STORE_DEPTH > 2) ? $clog2(STORE_DEPTH) : 1;
   localparam int NB   = $clog2(STORE_DEPTH + 1);
   localparam int SUMW = 16 + NB;
   localparam int SQW  = 31 + NB;
   localparam int NUMW = 31 + 2 * NB;
   localparam int MBW  = 16 + NB;
   localparam int DSW  = (2 * NB > 17) ? 2 * NB : 17;
   localparam int CMPW = (NB > WindowWidth) ? NB + 1 : WindowWidth + 1;
   localparam int CW   = $clog2(STORE_DEPTH + NUMW + 4);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_ACC  = 4'd1;
   localparam logic [3:0] ST_MSQ  = 4'd2;
   localparam logic [3:0] ST_MABS = 4'd3;
   localparam logic [3:0] ST_MDEN = 4'd4;
   localparam logic [3:0] ST_DVAR = 4'd5;
   localparam logic [3:0] ST_SQRT = 4'd6;
   localparam logic [3:0] ST_MAP0 = 4'd7;
   localparam logic [3:0] ST_MMAP = 4'd8;
   localparam logic [3:0] ST_DMAP = 4'd9;
   localparam logic [3:0] ST_DONE = 4'd10;

   // configuration
   logic [WindowWidth-1:0] window_ff, window_in;
   sample_type             hyst_low_ff, hyst_low_in;
   sample_type             hyst_high_ff, hyst_high_in;
   logic [SampleWidth-1:0] std_low_ff, std_low_in;
   logic [SampleWidth-1:0] std_high_ff, std_high_in;

   // control
   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NB-1:0] n_ff, n_in;
   logic [NB-1:0] widx_ff, widx_in;
   logic [NB-1:0] fill_ff, fill_in;
   logic          v1_ff, v1_in;
   logic          v2_ff, v2_in;
   logic          z1_ff, z1_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // datapath
   sample_type             mem [STORE_DEPTH];
   sample_type             rdata_ff;
   logic [AW-1:0]          rd_addr;
   sample_type             s2_ff, s2_in;
   logic [30:0]            sq_ff, sq_in;
   logic signed [SUMW-1:0] sum_ff, sum_in;
   logic [SQW-1:0]         sumsq_ff, sumsq_in;
   logic [NUMW-1:0]        mc_ff, mc_in;
   logic [MBW-1:0]         mb_ff, mb_in;
   logic [NUMW-1:0]        prod_ff, prod_in;
   logic [NUMW-1:0]        nsq_ff, nsq_in;
   logic [NUMW-1:0]        quo_ff, quo_in;
   logic [DSW-1:0]         rem_ff, rem_in;
   logic [DSW-1:0]         dsr_ff, dsr_in;
   logic [33:0]            sqv_ff, sqv_in;
   logic [18:0]            srem_ff, srem_in;
   logic [16:0]            root_ff, root_in;
   logic                   neg_ff, neg_in;
   logic                   eq_ff, eq_in;
   logic [SampleWidth-1:0] hyst_out_ff, hyst_out_in;
   logic [SampleWidth-1:0] sd_out_ff, sd_out_in;
   logic [IndexOutWidth-1:0] idx_out_ff, idx_out_in;

   // combinational helpers
   logic                   req_take;
   logic [CMPW-1:0]        win_ext;
   logic [NB-1:0]          n_eff;
   logic [NB-1:0]          w_eff;
   logic [NB-1:0]          w_next;
   sample_type             s1;
   logic [SUMW-1:0]        abs_sum;
   logic [NUMW-1:0]        prod_step;
   logic [DSW:0]           div_r2;
   logic                   div_bit;
   logic [DSW-1:0]         rem_step;
   logic [NUMW-1:0]        quo_step;
   logic [18:0]            sq_r;
   logic [18:0]            sq_trial;
   logic                   sq_ge;
   logic [16:0]            root_step;
   logic [15:0]            pom;
   logic signed [16:0]     map_a;
   logic signed [16:0]     map_b;
   logic signed [16:0]     map_d;
   logic [16:0]            map_a_mag;
   logic [16:0]            map_b_mag;
   logic [15:0]            map_d_mag;
   logic signed [NUMW+1:0] q_signed;
   logic signed [NUMW+1:0] hsum;
   logic [SampleWidth-1:0] hyst_sat;
   logic [NB+IndexOutWidth-1:0] widx_ext;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hyst_width = hyst_out_ff;
   assign rsp_std_dev    = sd_out_ff;
   assign rsp_next_index = idx_out_ff;

   always_comb begin
      win_ext = CMPW'(window_ff);
      if (win_ext < CMPW'(2)) begin
         n_eff = NB'(2);
      end else if (win_ext > CMPW'(STORE_DEPTH)) begin
         n_eff = NB'(STORE_DEPTH);
      end else begin
         n_eff = NB'(window_ff);
      end
      w_eff  = (widx_ff >= n_eff) ? '0 : widx_ff;
      w_next = w_eff + NB'(1);
   end

   assign rd_addr = cnt_ff[AW-1:0];
   assign s1 = z1_ff ? sample_type'(0) : rdata_ff;
   assign abs_sum = sum_ff[SUMW-1] ? SUMW'(-sum_ff) : SUMW'(sum_ff);

   assign prod_step = prod_ff + (mb_ff[0] ? mc_ff : '0);

   always_comb begin
      div_r2   = {rem_ff, quo_ff[NUMW-1]};
      div_bit  = (div_r2 >= {1'b0, dsr_ff});
      rem_step = div_bit ? DSW'(div_r2 - {1'b0, dsr_ff}) : div_r2[DSW-1:0];
      quo_step = {quo_ff[NUMW-2:0], div_bit};
   end

   always_comb begin
      sq_r      = {srem_ff[16:0], sqv_ff[33:32]};
      sq_trial  = {root_ff, 2'b01};
      sq_ge     = (sq_r >= sq_trial);
      root_step = {root_ff[15:0], sq_ge};
   end

   always_comb begin
      pom       = (root_ff[15:0] > std_high_ff) ? std_high_ff : root_ff[15:0];
      map_a     = 17'(hyst_high_ff) - 17'(hyst_low_ff);
      map_b     = $signed({1'b0, pom}) - $signed({1'b0, std_low_ff});
      map_d     = $signed({1'b0, std_high_ff}) - $signed({1'b0, std_low_ff});
      map_a_mag = map_a[16] ? 17'(-map_a) : 17'(map_a);
      map_b_mag = map_b[16] ? 17'(-map_b) : 17'(map_b);
      map_d_mag = map_d[16] ? 16'(-map_d) : map_d[15:0];
   end

   always_comb begin
      q_signed = neg_ff ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff});
      hsum     = q_signed + (NUMW+2)'(hyst_low_ff);
      if (!hsum[NUMW+1] && (|hsum[NUMW:15])) begin
         hyst_sat = 16'h7fff;
      end else if (hsum[NUMW+1] && !(&hsum[NUMW:15])) begin
         hyst_sat = 16'h8000;
      end else begin
         hyst_sat = hsum[15:0];
      end
   end

   assign widx_ext = (NB+IndexOutWidth)'(widx_ff);

   // configuration registers
   always_comb begin
      window_in    = window_ff;
      hyst_low_in  = hyst_low_ff;
      hyst_high_in = hyst_high_ff;
      std_low_in   = std_low_ff;
      std_high_in  = std_high_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WINDOW_SIZE: window_in    = csr_data[WindowWidth-1:0];
            CSR_HYST_LOW:    hyst_low_in  = csr_data;
            CSR_HYST_HIGH:   hyst_high_in = csr_data;
            CSR_STD_LOW:     std_low_in   = csr_data;
            CSR_STD_HIGH:    std_high_in  = csr_data;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      n_in      = n_ff;
      widx_in   = widx_ff;
      fill_in   = fill_ff;
      v1_in     = 1'b0;
      z1_in     = 1'b0;
      v2_in     = v1_ff;
      s2_in     = s1;
      sq_in     = 31'(s1 * s1);
      sum_in    = sum_ff;
      sumsq_in  = sumsq_ff;
      mc_in     = mc_ff;
      mb_in     = mb_ff;
      prod_in   = prod_ff;
      nsq_in    = nsq_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      sqv_in    = sqv_ff;
      srem_in   = srem_ff;
      root_in   = root_ff;
      neg_in    = neg_ff;
      eq_in     = eq_ff;
      hyst_out_in  = hyst_out_ff;
      sd_out_in    = sd_out_ff;
      idx_out_in   = idx_out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (v2_ff) begin
         sum_in   = sum_ff + SUMW'(s2_ff);
         sumsq_in = sumsq_ff + SQW'(sq_ff);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               n_in     = n_eff;
               widx_in  = w_next;
               fill_in  = (w_next > fill_ff) ? w_next : fill_ff;
               cnt_in   = '0;
               sum_in   = '0;
               sumsq_in = '0;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            v1_in  = (cnt_ff < CW'(n_ff));
            z1_in  = (cnt_ff >= CW'(fill_ff));
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(n_ff) + CW'(2)) begin
               mc_in    = NUMW'(sumsq_ff);
               mb_in    = MBW'(n_ff);
               prod_in  = '0;
               cnt_in   = '0;
               state_in = ST_MSQ;
            end
         end
         ST_MSQ, ST_MABS, ST_MDEN, ST_MMAP: begin
            prod_in = prod_step;
            mc_in   = {mc_ff[NUMW-2:0], 1'b0};
            mb_in   = {1'b0, mb_ff[MBW-1:1]};
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff == CW'(MBW - 1)) begin
               cnt_in  = '0;
               prod_in = '0;
               unique case (state_ff)
                  ST_MSQ: begin
                     nsq_in   = prod_step;
                     mc_in    = NUMW'(abs_sum);
                     mb_in    = MBW'(abs_sum);
                     state_in = ST_MABS;
                  end
                  ST_MABS: begin
                     quo_in   = nsq_ff - prod_step;
                     mc_in    = NUMW'(n_ff);
                     mb_in    = MBW'(n_ff - NB'(1));
                     state_in = ST_MDEN;
                  end
                  ST_MDEN: begin
                     dsr_in   = prod_step[DSW-1:0];
                     rem_in   = '0;
                     state_in = ST_DVAR;
                  end
                  default: begin
                     quo_in   = prod_step;
                     dsr_in   = DSW'(map_d_mag);
                     rem_in   = '0;
                     neg_in   = neg_ff ^ map_d[16];
                     state_in = ST_DMAP;
                  end
               endcase
            end
         end
         ST_DVAR, ST_DMAP: begin
            quo_in = quo_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(NUMW - 1)) begin
               cnt_in = '0;
               if (state_ff == ST_DVAR) begin
                  sqv_in   = quo_step[33:0];
                  srem_in  = '0;
                  root_in  = '0;
                  state_in = ST_SQRT;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SQRT: begin
            sqv_in  = {sqv_ff[31:0], 2'b00};
            srem_in = sq_ge ? 19'(sq_r - sq_trial) : sq_r;
            root_in = root_step;
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff == CW'(16)) begin
               cnt_in   = '0;
               state_in = ST_MAP0;
            end
         end
         ST_MAP0: begin
            eq_in   = (std_high_ff == std_low_ff);
            mc_in   = NUMW'(map_a_mag);
            mb_in   = MBW'(map_b_mag);
            prod_in = '0;
            neg_in  = map_a[16] ^ map_b[16];
            cnt_in  = '0;
            state_in = (std_high_ff == std_low_ff) ? ST_DONE : ST_MMAP;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               hyst_out_in  = eq_ff ? hyst_low_ff : hyst_sat;
               sd_out_in    = root_ff[15:0];
               idx_out_in   = widx_ext[IndexOutWidth-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sample store
   always_ff @(posedge clock) begin
      if (req_take) begin
         mem[w_eff[AW-1:0]] <= req_torque_sample;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         hyst_low_ff  <= '0;
         hyst_high_ff <= '0;
         std_low_ff   <= '0;
         std_high_ff  <= STD_HIGH_RESET;
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         n_ff         <= '0;
         widx_ff      <= '0;
         fill_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         z1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         hyst_low_ff  <= hyst_low_in;
         hyst_high_ff <= hyst_high_in;
         std_low_ff   <= std_low_in;
         std_high_ff  <= std_high_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
         widx_ff      <= widx_in;
         fill_ff      <= fill_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         z1_ff        <= z1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff       <= s2_in;
      sq_ff       <= sq_in;
      sum_ff      <= sum_in;
      sumsq_ff    <= sumsq_in;
      mc_ff       <= mc_in;
      mb_ff       <= mb_in;
      prod_ff     <= prod_in;
      nsq_ff      <= nsq_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dsr_ff      <= dsr_in;
      sqv_ff      <= sqv_in;
      srem_ff     <= srem_in;
      root_ff     <= root_in;
      neg_ff      <= neg_in;
      eq_ff       <= eq_in;
      hyst_out_ff <= hyst_out_in;
      sd_out_ff   <= sd_out_in;
      idx_out_ff  <= idx_out_in;
   end

endmodule
